/* sv/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared constants of the byte ring FIFO: default store depth and op codes.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    // Default number of entries in the ring store
    localparam int DEPTH_DEFAULT = 256;

    // Widths of the command fields
    localparam int MODE_W = 3;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 9;

    // Reset value of the size register
    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

    // Operation codes carried in the mode field
    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FPUSH   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SKIP    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RSTPTR  = 3'd6;

endpackage

`default_nettype wire

/* sv/byte_ring_fifo.sv */
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring FIFO, one slot kept empty, one command per cycle while not busy.
// ----------------------------------------------------------------------------
// Usage:
//   A command (i_mode, i_data_byte, i_amount) is taken on a rising edge with
//   start high and busy low. Every command returns one result in the next
//   cycle, shown for one cycle with o_strobe high; the receiver cannot stall
//   and need not, since results never back up.
//   Throughput: one command per cycle while busy is low. The result is
//   registered, o_read_byte by the registered read port of the ring store.
//   Status fields (used, free, empty, full) are computed from the pointer
//   registers, which hold the state left by the command being reported.
//   The size register is written through i_cfg_valid/o_cfg_ready; a write
//   also returns both pointers to zero and keeps the store contents.
//   Reset: the pointers clear and the size goes to 256, then a clearing pass
//   writes zero to every store entry, with busy high. Configuration writes
//   are taken during the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // command channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [brf_pkg::MODE_W-1:0]  i_mode,
    input  wire logic [brf_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire logic [brf_pkg::BYTE_W-1:0]  i_amount,
    // result channel
    output logic                             o_strobe,
    output logic      [brf_pkg::BYTE_W-1:0]  o_read_byte,
    output logic                             o_accepted,
    output logic      [brf_pkg::BYTE_W-1:0]  o_amount_done,
    output logic      [brf_pkg::BYTE_W-1:0]  o_used_count,
    output logic      [brf_pkg::BYTE_W-1:0]  o_free_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    // configuration channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [brf_pkg::SIZE_W-1:0]  i_cfg_data
);

    import brf_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = ((PW > SIZE_W) ? PW : SIZE_W) + 1;
    localparam int SMAX = (DEPTH < 511) ? DEPTH : 511;
    localparam logic [SIZE_W-1:0] SMAX_S = SIZE_W'(SMAX);
    localparam logic [PW-1:0]     LAST   = PW'(DEPTH - 1);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [SIZE_W-1:0] r_size;
    logic [PW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_rp, n_rp;
    logic              r_clearing;
    logic [PW-1:0]     r_clr_addr;
    logic              r_strobe;
    logic              r_rd_sel, n_rd_sel;
    logic              r_acc, n_acc;
    logic [BYTE_W-1:0] r_done, n_done;

    logic              accept;
    logic              cfg_wr;
    logic              push_we;
    logic [BYTE_W-1:0] ram_q;

    // Clamped ring size and pointers, widened for arithmetic
    logic [CW-1:0] ring_s;
    logic [CW-1:0] wp_x;
    logic [CW-1:0] rp_x;
    logic [CW-1:0] used_c;
    logic [CW-1:0] free_c;
    logic          full_c;
    logic          empty_c;
    logic [CW-1:0] wp_step;
    logic [CW-1:0] rp_step;
    logic [CW-1:0] amt_x;
    logic [CW-1:0] wp_sum;
    logic [CW-1:0] rp_sum;
    logic [CW-1:0] wp_p1;

    assign accept      = start && !busy;
    assign busy        = r_clearing;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // Size clamp to the range the store supports
    always_comb begin
        if (r_size < SIZE_W'(2)) begin
            ring_s = CW'(2);
        end else if (r_size > SMAX_S) begin
            ring_s = CW'(SMAX_S);
        end else begin
            ring_s = CW'(r_size);
        end
    end

    // Status from the current pointers
    assign wp_x    = CW'(r_wp);
    assign rp_x    = CW'(r_rp);
    assign used_c  = (wp_x >= rp_x) ? (wp_x - rp_x) : (ring_s + wp_x - rp_x);
    assign free_c  = ring_s - CW'(1) - used_c;
    assign empty_c = (r_wp == r_rp);
    assign wp_p1   = ((wp_x + CW'(1)) >= ring_s) ? CW'(0) : (wp_x + CW'(1));
    assign full_c  = (wp_p1 == rp_x);
    assign amt_x   = CW'(i_amount);

    // Command decode: pointer steps, store write and result flags
    always_comb begin
        wp_step  = '0;
        rp_step  = '0;
        push_we  = 1'b0;
        n_rd_sel = 1'b0;
        n_acc    = 1'b0;
        n_done   = '0;
        unique case (i_mode) inside
            MODE_PUSH: begin
                if (!full_c) begin
                    push_we = 1'b1;
                    wp_step = CW'(1);
                    n_acc   = 1'b1;
                end
            end
            MODE_FPUSH: begin
                if (full_c) begin
                    rp_step = CW'(1);
                end
                push_we = 1'b1;
                wp_step = CW'(1);
                n_acc   = 1'b1;
            end
            MODE_POP, MODE_PEEK: begin
                if (!empty_c) begin
                    n_rd_sel = 1'b1;
                    n_acc    = 1'b1;
                    if (i_mode == MODE_POP) begin
                        rp_step = CW'(1);
                    end
                end
            end
            MODE_SKIP: begin
                rp_step = (amt_x < used_c) ? amt_x : used_c;
                n_done  = rp_step[BYTE_W-1:0];
            end
            MODE_RESERVE: begin
                wp_step = (amt_x < free_c) ? amt_x : free_c;
                n_done  = wp_step[BYTE_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // Modular pointer advance: one compare and subtract, steps stay below size
    assign wp_sum = wp_x + wp_step;
    assign rp_sum = rp_x + rp_step;

    always_comb begin
        if (i_mode == MODE_RSTPTR) begin
            n_wp = '0;
            n_rp = '0;
        end else begin
            n_wp = (wp_sum >= ring_s) ? PW'(wp_sum - ring_s) : PW'(wp_sum);
            n_rp = (rp_sum >= ring_s) ? PW'(rp_sum - ring_s) : PW'(rp_sum);
        end
    end

    // Control and pointer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_RESET;
            r_wp       <= '0;
            r_rp       <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= accept;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + PW'(1);
                if (r_clr_addr == LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (cfg_wr) begin
                r_size <= i_cfg_data;
                r_wp   <= '0;
                r_rp   <= '0;
            end else if (accept) begin
                r_wp <= n_wp;
                r_rp <= n_rp;
            end
        end
    end

    // Result payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_sel <= n_rd_sel;
            r_acc    <= n_acc;
            r_done   <= n_done;
        end
    end

    // Ring store: clearing pass owns the write port after reset
    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r_clearing || (accept && push_we)),
        .i_waddr (r_clearing ? r_clr_addr : r_wp),
        .i_wdata (r_clearing ? '0 : i_data_byte),
        .i_raddr (r_rp),
        .o_rdata (ram_q)
    );

    // Result outputs
    assign o_strobe      = r_strobe;
    assign o_read_byte   = r_rd_sel ? ram_q : '0;
    assign o_accepted    = r_acc;
    assign o_amount_done = r_done;
    assign o_used_count  = used_c[BYTE_W-1:0];
    assign o_free_count  = free_c[BYTE_W-1:0];
    assign o_is_empty    = empty_c;
    assign o_is_full     = full_c;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_strobe_follows_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) accept |=> o_strobe
    ) else $error("accepted transaction produced no result");

    a_no_strobe_without_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) !accept |=> !o_strobe
    ) else $error("result without an accepted transaction");

    a_ptrs_in_ring: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) (wp_x < ring_s) && (rp_x < ring_s)
    ) else $error("pointer outside the ring");

    a_empty_full_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) o_is_empty |-> !o_is_full
    ) else $error("ring reported empty and full together");

endmodule

`default_nettype wire

/* sv/brf_ram.sv */
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port (read returns old data on collision)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
